[hw/rtl/mpe_pkg.sv]
package mpe_pkg;

  // Fixed-point format and count width
  localparam int FRAC_BITS       = 18;
  localparam int STEP_GUARD_BITS = 12;
  localparam int COUNT_BITS      = 16;

  // Field widths
  localparam int COORD_W    = 23;  // window corners and per-pixel steps
  localparam int WIDTH_W    = 8;   // image_width
  localparam int HEIGHT_W   = 7;   // image_height
  localparam int LIMIT_W    = 16;  // max_iter and the iteration counter
  localparam int PX_W       = 7;
  localparam int PY_W       = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  // Step divider: magnitude of the span, widened by the guard bits
  localparam int DIV_W      = WIDTH_W;
  localparam int DIVIDEND_W = COORD_W + STEP_GUARD_BITS;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Iteration datapath. c needs COORD_W + PX_W bits; z stays within c plus
  // a few units of the escape bound while the iteration runs.
  localparam int Z_W    = COORD_W + PX_W + 2;
  localparam int PROD_W = 2 * Z_W;
  localparam int SQ_W   = PROD_W - FRAC_BITS;

  localparam logic [SQ_W:0] ESCAPE_BOUND = (SQ_W + 1)'(64'd4 << FRAC_BITS);
  localparam logic [LIMIT_W-1:0] COUNT_MASK = LIMIT_W'((64'd1 << COUNT_BITS) - 64'd1);

  // Step saturation limits and rounding constant for the floor shift
  localparam logic [DIVIDEND_W:0] STEP_POS_MAX = (DIVIDEND_W + 1)'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic [DIVIDEND_W:0] STEP_NEG_MAG = (DIVIDEND_W + 1)'(64'd1 << (COORD_W - 1));
  localparam logic [DIVIDEND_W:0] GUARD_ONES   = (DIVIDEND_W + 1)'((64'd1 << STEP_GUARD_BITS) - 64'd1);

  // Register reset values
  localparam logic signed [COORD_W-1:0] RST_LEFT_REAL   = COORD_W'(-196608);
  localparam logic signed [COORD_W-1:0] RST_TOP_IMAG    = COORD_W'(-196608);
  localparam logic signed [COORD_W-1:0] RST_RIGHT_REAL  = COORD_W'(196608);
  localparam logic signed [COORD_W-1:0] RST_BOTTOM_IMAG = COORD_W'(196608);
  localparam logic [WIDTH_W-1:0]        RST_WIDTH       = WIDTH_W'(96);
  localparam logic [HEIGHT_W-1:0]       RST_HEIGHT      = HEIGHT_W'(64);
  localparam logic [LIMIT_W-1:0]        RST_MAX_ITER    = LIMIT_W'(255);

  // Pixel queue between front and back; depth is a power of two
  localparam int Q_PTR_W = 1;
  localparam int Q_DEPTH = 1 << Q_PTR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_REAL,
    REG_TOP_IMAG,
    REG_RIGHT_REAL,
    REG_BOTTOM_IMAG,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_MAX_ITER
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STP_LOAD_RE,
    STP_RUN_RE,
    STP_LOAD_IM,
    STP_RUN_IM,
    STP_DONE
  } step_state_t;

  typedef enum logic [1:0] {
    IT_IDLE,
    IT_CHECK,
    IT_MUL
  } iter_state_t;

  typedef struct packed {
    logic signed [Z_W-1:0] cr;
    logic signed [Z_W-1:0] ci;
    logic [PX_W-1:0]       px;
    logic [PY_W-1:0]       py;
  } item_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIV_W-1:0]      divisor;
  } div_req_t;

endpackage

[hw/rtl/mpe_div.sv]
module mpe_div
  import mpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_req_t              div_req,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [DIV_W-1:0]      div_r;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_W:0]        trial;
  logic                  fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial    = {rem_r, quo_r[DIVIDEND_W-1]};
    fits     = trial >= {1'b0, div_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (div_req.start) begin
      quo_nxt = div_req.dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (div_req.start) begin
      div_r <= div_req.divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[hw/rtl/mpe_front.sv]
module mpe_front
  import mpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  input  logic [PX_W-1:0]       pixel_x,
  input  logic [PY_W-1:0]       pixel_y,
  input  q_status_t             q_status,
  output logic                  busy,
  output logic                  push,
  output item_t                 push_item,
  output logic [LIMIT_W-1:0]    max_iter
);

  logic signed [COORD_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [WIDTH_W-1:0]        width_r;
  logic [HEIGHT_W-1:0]       height_r;
  logic [LIMIT_W-1:0]        max_iter_r;

  step_state_t               st_r, st_nxt;
  logic signed [COORD_W-1:0] step_re_r, step_re_nxt;
  logic signed [COORD_W-1:0] step_im_r, step_im_nxt;

  div_req_t                  div_req;
  logic [DIVIDEND_W-1:0]     div_quot;
  logic                      div_done;

  logic                      sel_imag;
  logic signed [COORD_W-1:0] corner_a, corner_b;
  logic signed [COORD_W:0]   span;
  logic                      span_neg;
  logic [COORD_W:0]          span_abs;
  logic [DIV_W-1:0]          divisor;
  logic [DIVIDEND_W:0]       rounded;
  logic [DIVIDEND_W:0]       step_mag;
  logic signed [COORD_W-1:0] step_val;
  logic                      recalc;

  mpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .div_req  (div_req),
    .quotient (div_quot),
    .done     (div_done)
  );

  assign recalc = cfg_we && (cfg_index <= REG_MAX_ITER);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= RST_LEFT_REAL;
      top_r      <= RST_TOP_IMAG;
      right_r    <= RST_RIGHT_REAL;
      bottom_r   <= RST_BOTTOM_IMAG;
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
      max_iter_r <= RST_MAX_ITER;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_REAL:    left_r     <= cfg_data[COORD_W-1:0];
        REG_TOP_IMAG:     top_r      <= cfg_data[COORD_W-1:0];
        REG_RIGHT_REAL:   right_r    <= cfg_data[COORD_W-1:0];
        REG_BOTTOM_IMAG:  bottom_r   <= cfg_data[COORD_W-1:0];
        REG_IMAGE_WIDTH:  width_r    <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r   <= cfg_data[HEIGHT_W-1:0];
        REG_MAX_ITER:     max_iter_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Step operands: span magnitude goes through the divider, the sign is
  // applied afterwards together with the floor of the guard shift.
  always_comb begin
    sel_imag = (st_r == STP_LOAD_IM) || (st_r == STP_RUN_IM);
    corner_a = sel_imag ? top_r : left_r;
    corner_b = sel_imag ? bottom_r : right_r;
    span     = {corner_b[COORD_W-1], corner_b} - {corner_a[COORD_W-1], corner_a};
    span_neg = span[COORD_W];
    span_abs = span_neg ? (COORD_W + 1)'(-span) : span;
    divisor  = sel_imag ? DIV_W'(height_r) : width_r;

    div_req.start    = (st_r == STP_LOAD_RE) || (st_r == STP_LOAD_IM);
    div_req.dividend = DIVIDEND_W'(span_abs[COORD_W-1:0]) << STEP_GUARD_BITS;
    div_req.divisor  = divisor;

    rounded  = {1'b0, div_quot} + (span_neg ? GUARD_ONES : '0);
    step_mag = rounded >> STEP_GUARD_BITS;

    if (divisor == '0) begin
      step_val = '0;
    end else if (!span_neg) begin
      step_val = (step_mag > STEP_POS_MAX) ? STEP_POS_MAX[COORD_W-1:0]
                                           : step_mag[COORD_W-1:0];
    end else begin
      step_val = (step_mag > STEP_NEG_MAG) ? STEP_NEG_MAG[COORD_W-1:0]
                                           : COORD_W'(-step_mag[COORD_W-1:0]);
    end
  end

  // Step sequencer: real step, then imaginary step, on one shared divider.
  always_comb begin
    st_nxt      = st_r;
    step_re_nxt = step_re_r;
    step_im_nxt = step_im_r;
    case (st_r)
      STP_LOAD_RE: st_nxt = STP_RUN_RE;
      STP_RUN_RE: begin
        if (div_done) begin
          step_re_nxt = step_val;
          st_nxt      = STP_LOAD_IM;
        end
      end
      STP_LOAD_IM: st_nxt = STP_RUN_IM;
      STP_RUN_IM: begin
        if (div_done) begin
          step_im_nxt = step_val;
          st_nxt      = STP_DONE;
        end
      end
      STP_DONE: st_nxt = STP_DONE;
      default:  st_nxt = STP_LOAD_RE;
    endcase
    if (recalc) begin
      st_nxt = STP_LOAD_RE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STP_LOAD_RE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_re_r <= step_re_nxt;
    step_im_r <= step_im_nxt;
  end

  // Request intake: form c and hand it to the queue.
  assign busy = (st_r != STP_DONE) || q_status.full;
  assign push = start && !busy;

  always_comb begin
    push_item.cr = Z_W'(left_r) + Z_W'(step_re_r) * Z_W'($signed({1'b0, pixel_x}));
    push_item.ci = Z_W'(top_r) + Z_W'(step_im_r) * Z_W'($signed({1'b0, pixel_y}));
    push_item.px = pixel_x;
    push_item.py = pixel_y;
  end

  assign max_iter = max_iter_r;

endmodule

[hw/rtl/mpe_queue.sv]
module mpe_queue
  import mpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output q_status_t q_status
);

  item_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (Q_PTR_W + 1)'(push) - (Q_PTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item           = slot_r[rd_ptr_r];
  assign q_status.full      = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign q_status.not_empty = (count_r != '0);

endmodule

[hw/rtl/mpe_iter.sv]
module mpe_iter
  import mpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  q_status_t          q_status,
  input  item_t              pop_item,
  input  logic [LIMIT_W-1:0] max_iter,
  output logic               pop,
  output logic               out_valid,
  output logic [PX_W-1:0]    out_x,
  output logic [PY_W-1:0]    out_y,
  output logic [LIMIT_W-1:0] out_iterations
);

  iter_state_t           st_r, st_nxt;
  logic signed [Z_W-1:0] cr_r, ci_r, x_r, y_r, xy_r;
  logic signed [Z_W-1:0] cr_nxt, ci_nxt, x_nxt, y_nxt, xy_nxt;
  logic [SQ_W-1:0]       x2_r, y2_r, x2_nxt, y2_nxt;
  logic [LIMIT_W-1:0]    n_r, n_nxt;
  logic [PX_W-1:0]       px_r, px_nxt;
  logic [PY_W-1:0]       py_r, py_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PX_W-1:0]       out_x_r, out_x_nxt;
  logic [PY_W-1:0]       out_y_r, out_y_nxt;
  logic [LIMIT_W-1:0]    out_n_r, out_n_nxt;

  logic signed [PROD_W-1:0] prod_xx, prod_yy, prod_xy;
  logic [SQ_W:0]            mag2;
  logic                     stop;
  logic signed [Z_W-1:0]    x_new, y_new;

  always_comb begin
    prod_xx = x_r * x_r;
    prod_yy = y_r * y_r;
    prod_xy = x_r * y_r;
    mag2    = {1'b0, x2_r} + {1'b0, y2_r};
    stop    = (mag2 > ESCAPE_BOUND) || (n_r >= max_iter);
    // Only used while |z|^2 is within the bound, so the low bits suffice.
    x_new   = $signed(x2_r[Z_W-1:0]) - $signed(y2_r[Z_W-1:0]) + cr_r;
    y_new   = $signed({xy_r[Z_W-2:0], 1'b0}) + ci_r;
  end

  always_comb begin
    st_nxt        = st_r;
    pop           = 1'b0;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    xy_nxt        = xy_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    n_nxt         = n_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    out_valid_nxt = 1'b0;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_n_nxt     = out_n_r;
    case (st_r)
      IT_IDLE: begin
        if (q_status.not_empty) begin
          pop    = 1'b1;
          cr_nxt = pop_item.cr;
          ci_nxt = pop_item.ci;
          px_nxt = pop_item.px;
          py_nxt = pop_item.py;
          x_nxt  = '0;
          y_nxt  = '0;
          xy_nxt = '0;
          x2_nxt = '0;
          y2_nxt = '0;
          n_nxt  = '0;
          st_nxt = IT_CHECK;
        end
      end
      IT_CHECK: begin
        if (stop) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = px_r;
          out_y_nxt     = py_r;
          out_n_nxt     = n_r & COUNT_MASK;
          st_nxt        = IT_IDLE;
        end else begin
          x_nxt  = x_new;
          y_nxt  = y_new;
          n_nxt  = n_r + 1'b1;
          st_nxt = IT_MUL;
        end
      end
      IT_MUL: begin
        x2_nxt = prod_xx[PROD_W-1:FRAC_BITS];
        y2_nxt = prod_yy[PROD_W-1:FRAC_BITS];
        xy_nxt = prod_xy[Z_W+FRAC_BITS-1:FRAC_BITS];
        st_nxt = IT_CHECK;
      end
      default: st_nxt = IT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= IT_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_r    <= cr_nxt;
    ci_r    <= ci_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    xy_r    <= xy_nxt;
    x2_r    <= x2_nxt;
    y2_r    <= y2_nxt;
    n_r     <= n_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_n_r <= out_n_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_iterations = out_n_r;

endmodule

[hw/rtl/mandelbrot_pixel_engine_unit.sv]
// Channel        Handshake             Payload
// pixel request  start / busy          in_pixel_x, in_pixel_y
// result         out_valid (strobe)    out_x, out_y, out_iterations
// configuration  cfg_we                cfg_index, cfg_data
//
// The iteration unit loads a request, then spends on each z update a multiply state (the three
// squares and products) and a check/add state, and ends with a final check. The result strobe
// is registered after that check; up to two more requests queue meanwhile.
// Reset is synchronous; after reset and after every register write the two pixel steps are
// recomputed on one shared bit-serial divider with busy high. busy also rises while the
// request queue is full. Results cannot be stalled by the receiver.
module mandelbrot_pixel_engine_unit
  import mpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [PX_W-1:0]       in_pixel_x,
  input  logic [PY_W-1:0]       in_pixel_y,
  output logic                  out_valid,
  output logic [PX_W-1:0]       out_x,
  output logic [PY_W-1:0]       out_y,
  output logic [LIMIT_W-1:0]    out_iterations
);

  // Front: holds the configuration, derives the steps and turns each accepted
  // request into the point c = corner + step * pixel.
  logic               push;
  item_t              push_item;
  logic               pop;
  item_t              pop_item;
  q_status_t          q_status;
  logic [LIMIT_W-1:0] max_iter;

  mpe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .pixel_x   (in_pixel_x),
    .pixel_y   (in_pixel_y),
    .q_status  (q_status),
    .busy      (busy),
    .push      (push),
    .push_item (push_item),
    .max_iter  (max_iter)
  );

  // Short queue so that the front keeps taking requests while a long
  // iteration runs in the back.
  mpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  // Back: the escape-time iteration and the registered result.
  mpe_iter u_iter (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .pop_item       (pop_item),
    .max_iter       (max_iter),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_iterations (out_iterations)
  );

  // A register write must invalidate the steps before the next request.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index <= REG_MAX_ITER)) |=> busy)
    else $error("request window open right after a register write");

  // Leaving reset, the steps are still being derived.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low straight after reset");

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("pixel queue overflow");

  // Every result needs at least a load and a check state in the back.
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

endmodule

[dv/mandelbrot_pixel_engine_unit_tb.sv]
module mandelbrot_pixel_engine_unit_tb;
  import mpe_pkg::*;

  // The slowest correct stretch without any handshake is a single pixel that never escapes
  // under the full 16 bit limit in the iteration unit. The watchdog allows a little over four
  // times that stretch before it calls the run hung.
  localparam int unsigned IDLE_LIMIT  = 600000;
  localparam int unsigned ITEM_TARGET = 1750;
  // Settling time after the last result, enough for a stray extra strobe to show itself.
  localparam int unsigned TAIL_CYCLES = 64;

  typedef struct {
    logic [PX_W-1:0] x;
    logic [PY_W-1:0] y;
    int unsigned     gap;
  } pixel_req_t;

  typedef struct {
    logic [PX_W-1:0]    x;
    logic [PY_W-1:0]    y;
    logic [LIMIT_W-1:0] count;
  } pixel_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PX_W-1:0]       in_pixel_x = '0;
  logic [PY_W-1:0]       in_pixel_y = '0;
  logic                  out_valid;
  logic [PX_W-1:0]       out_x;
  logic [PY_W-1:0]       out_y;
  logic [LIMIT_W-1:0]    out_iterations;

  mandelbrot_pixel_engine_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .out_valid      (out_valid),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_iterations (out_iterations)
  );

  always #2 clk = ~clk;

  // Shadow copy of the window registers and of the two derived pixel steps.
  logic signed [COORD_W-1:0] win_left;
  logic signed [COORD_W-1:0] win_top;
  logic signed [COORD_W-1:0] win_right;
  logic signed [COORD_W-1:0] win_bottom;
  logic [WIDTH_W-1:0]        win_width;
  logic [HEIGHT_W-1:0]       win_height;
  logic [LIMIT_W-1:0]        iter_limit;
  logic signed [COORD_W-1:0] step_re;
  logic signed [COORD_W-1:0] step_im;

  pixel_req_t    pixel_queue[$];
  pixel_result_t expected_counts[$];

  // Driver state. The monitor raises req_taken when it sees the request accepted; the driver
  // clears it at the following falling edge, so the two never touch it in the same time step.
  logic        holding = 1'b0;
  logic        staged = 1'b0;
  logic        req_taken = 1'b0;
  pixel_req_t  staged_req;
  int unsigned wait_left = 0;
  logic        burst = 1'b0;

  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned windows_used = 0;
  int unsigned top_count = 0;
  int unsigned idle_cycles = 0;

  // Per-pixel step: the span is widened by the guard bits, divided with truncation toward
  // zero, floored back down and then clamped to the signed coordinate range. A zero divisor
  // gives a zero step.
  function automatic logic signed [COORD_W-1:0] pixel_step(longint a, longint b, longint div);
    longint span;
    longint q;
    if (div == 0) begin
      return '0;
    end
    span = b - a;
    q = (span <<< STEP_GUARD_BITS) / div;
    q = q >>> STEP_GUARD_BITS;
    if (q > (longint'(1) <<< (COORD_W - 1)) - 1) begin
      q = (longint'(1) <<< (COORD_W - 1)) - 1;
    end
    if (q < -(longint'(1) <<< (COORD_W - 1))) begin
      q = -(longint'(1) <<< (COORD_W - 1));
    end
    return q[COORD_W-1:0];
  endfunction

  function automatic void refresh_steps();
    step_re = pixel_step(longint'(win_left), longint'(win_right), longint'(win_width));
    step_im = pixel_step(longint'(win_top), longint'(win_bottom), longint'(win_height));
  endfunction

  // Escape-time count. Every intermediate fits comfortably in 64 bits for coordinates
  // within +/-8.0, so plain longint arithmetic is exact here.
  function automatic int unsigned escape_count(longint cr, longint ci, int unsigned limit);
    longint      x;
    longint      y;
    longint      x2;
    longint      y2;
    longint      xn;
    longint      bound;
    int unsigned n;
    x = 0;
    y = 0;
    x2 = 0;
    y2 = 0;
    n = 0;
    bound = longint'(4) <<< FRAC_BITS;
    while ((x2 + y2) <= bound && n < limit) begin
      xn = x2 - y2 + cr;
      y = 2 * ((x * y) >>> FRAC_BITS) + ci;
      x = xn;
      x2 = (x * x) >>> FRAC_BITS;
      y2 = (y * y) >>> FRAC_BITS;
      n++;
    end
    return n;
  endfunction

  function automatic longint coord_between(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  // Register writes are presented at the falling edge and land at the next rising edge. The
  // shadow copy is updated at once, which is safe because nothing is in flight meanwhile.
  task automatic write_reg(cfg_reg_t idx, longint value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_LEFT_REAL:    win_left = value[COORD_W-1:0];
      REG_TOP_IMAG:     win_top = value[COORD_W-1:0];
      REG_RIGHT_REAL:   win_right = value[COORD_W-1:0];
      REG_BOTTOM_IMAG:  win_bottom = value[COORD_W-1:0];
      REG_IMAGE_WIDTH:  win_width = value[WIDTH_W-1:0];
      REG_IMAGE_HEIGHT: win_height = value[HEIGHT_W-1:0];
      REG_MAX_ITER:     iter_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
    refresh_steps();
  endtask

  // Holds until every queued request has been accepted and every result has come back.
  task automatic drain();
    while (!(pixel_queue.size() == 0 && !staged && !holding && expected_counts.size() == 0))
      @(negedge clk);
  endtask

  // Reprograms the whole window while the engine is idle, then waits for the step
  // recomputation to finish so that the next phase starts from settled steps.
  task automatic set_window(longint l, longint t, longint r, longint b,
                            longint w, longint h, longint m);
    drain();
    while (busy) @(negedge clk);
    write_reg(REG_LEFT_REAL, l);
    write_reg(REG_TOP_IMAG, t);
    write_reg(REG_RIGHT_REAL, r);
    write_reg(REG_BOTTOM_IMAG, b);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_MAX_ITER, m);
    @(negedge clk);
    cfg_we <= 1'b0;
    while (busy) @(negedge clk);
    windows_used++;
  endtask

  task automatic queue_pixel(int unsigned px, int unsigned py);
    pixel_req_t req;
    req.x   = px[PX_W-1:0];
    req.y   = py[PY_W-1:0];
    req.gap = burst ? 0 : $urandom_range(0, 8);
    pixel_queue.push_back(req);
  endtask

  // Request driver. At most one nonblocking assignment to start per falling edge: it is left
  // alone while a request waits for acceptance, and a back-to-back request keeps it high.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (holding && req_taken) begin
        holding   = 1'b0;
        req_taken = 1'b0;
      end
      if (!holding && !staged && pixel_queue.size() != 0) begin
        staged_req = pixel_queue.pop_front();
        staged     = 1'b1;
        wait_left  = staged_req.gap;
      end
      if (holding) begin
        // Keep the current request on the ports until the engine takes it.
      end else if (staged && wait_left == 0) begin
        in_pixel_x <= staged_req.x;
        in_pixel_y <= staged_req.y;
        start      <= 1'b1;
        holding    = 1'b1;
        staged     = 1'b0;
      end else begin
        // Idle cycle: the pixel ports carry noise that the engine must ignore.
        start      <= 1'b0;
        in_pixel_x <= PX_W'($urandom);
        in_pixel_y <= PY_W'($urandom);
        if (staged) begin
          wait_left--;
        end
      end
    end
  end

  // Monitor: checks each result strobe against the oldest prediction, then records any request
  // accepted at this edge together with its predicted escape count. It also runs the watchdog.
  always @(posedge clk) begin : monitor
    pixel_result_t want;
    pixel_result_t pred;
    longint        cr;
    longint        ci;
    int unsigned   n;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (expected_counts.size() == 0) begin
          $display("%0t: result (%0d, %0d, %0d) with no request outstanding", $time,
                   out_x, out_y, out_iterations);
          mismatches++;
        end else begin
          want = expected_counts.pop_front();
          if (out_x !== want.x) begin
            $display("%0t: out_x mismatch, expected %0d, got %0d", $time, want.x, out_x);
            mismatches++;
          end
          if (out_y !== want.y) begin
            $display("%0t: out_y mismatch, expected %0d, got %0d", $time, want.y, out_y);
            mismatches++;
          end
          if (out_iterations !== want.count) begin
            $display("%0t: iterations mismatch at (%0d, %0d), expected %0d, got %0d", $time,
                     want.x, want.y, want.count, out_iterations);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        cr = longint'(win_left) + longint'(step_re) * longint'(in_pixel_x);
        ci = longint'(win_top) + longint'(step_im) * longint'(in_pixel_y);
        n  = escape_count(cr, ci, int'(iter_limit));
        pred.x     = in_pixel_x;
        pred.y     = in_pixel_y;
        pred.count = n[LIMIT_W-1:0] & COUNT_MASK;
        if (n > top_count) begin
          top_count = n;
        end
        expected_counts.push_back(pred);
        pixels_sent++;
        req_taken = 1'b1;
      end
      if ((start && !busy) || out_valid || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request or result for %0d cycles", $time, idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : stimulus
    longint      l;
    longint      t;
    longint      r;
    longint      b;
    longint      w;
    longint      h;
    longint      m;
    int unsigned kind;
    int unsigned count;
    int unsigned px;
    int unsigned py;

    // The shadow copy starts from the register reset values, exactly as the engine does.
    win_left   = RST_LEFT_REAL;
    win_top    = RST_TOP_IMAG;
    win_right  = RST_RIGHT_REAL;
    win_bottom = RST_BOTTOM_IMAG;
    win_width  = RST_WIDTH;
    win_height = RST_HEIGHT;
    iter_limit = RST_MAX_ITER;
    refresh_steps();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);

    // Reset window, -0.75 to 0.75 on both axes. Pixel (48, 32) lands exactly on the origin and
    // runs to the limit; the four corner pixels escape.
    queue_pixel(0, 0);
    queue_pixel(127, 63);
    queue_pixel(48, 32);
    queue_pixel(127, 0);
    queue_pixel(0, 63);
    queue_pixel(60, 20);

    // Both divisors zero, so every pixel sits on corner A; with a zero limit the count is
    // zero whatever the point.
    set_window(0, 0, 1048576, -1048576, 0, 0, 0);
    queue_pixel(5, 7);
    queue_pixel(127, 63);

    // Spans from -8.0 to +8.0 over a single pixel: the horizontal step saturates at
    // the top of the signed range and the vertical one at the bottom.
    set_window(-2097152, 2097152, 2097152, -2097152, 1, 1, 255);
    queue_pixel(0, 0);
    queue_pixel(1, 1);
    queue_pixel(127, 63);

    // Full 16 bit limit. The origin never escapes, so its count comes back as all ones.
    burst = 1'b1;
    set_window(0, 0, 2097152, 2097152, 128, 64, 65535);
    queue_pixel(0, 0);
    queue_pixel(127, 63);
    burst = 1'b0;

    // The classic view of the set, with a limit above 255 so that the upper count bits move.
    set_window(-524288, -327680, 131072, 327680, 128, 64, 1000);
    queue_pixel(80, 32);
    queue_pixel(100, 30);
    queue_pixel(96, 40);
    queue_pixel(70, 10);
    queue_pixel(105, 20);
    queue_pixel(0, 32);
    queue_pixel(127, 63);
    queue_pixel(90, 45);

    // Random phases. Most windows sit around the set, so that pixels iterate for a while;
    // the rest are arbitrary windows, where most pixels escape at once.
    while (pixels_sent + pixel_queue.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        l = coord_between(-655360, -131072);
        r = l + coord_between(16384, 786432);
        t = coord_between(-393216, 131072);
        b = t + coord_between(16384, 786432);
        if ($urandom_range(0, 3) == 0) begin
          m = l;
          l = r;
          r = m;
        end
        if ($urandom_range(0, 3) == 0) begin
          m = t;
          t = b;
          b = m;
        end
        w = $urandom_range(1, 128);
        h = $urandom_range(1, 64);
        m = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 300) : $urandom_range(0, 64);
      end else begin
        l = coord_between(-2097152, 2097152);
        t = coord_between(-2097152, 2097152);
        r = coord_between(-2097152, 2097152);
        b = coord_between(-2097152, 2097152);
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 128);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 64);
        m = $urandom_range(0, 100);
      end
      burst = ($urandom_range(0, 3) == 0);
      set_window(l, t, r, b, w, h, m);
      count = $urandom_range(16, 64);
      repeat (count) begin
        // Mostly pixels inside the image; now and then any pixel the ports can carry.
        if (w == 0 || h == 0 || $urandom_range(0, 4) == 0) begin
          px = $urandom_range(0, 127);
          py = $urandom_range(0, 63);
        end else begin
          px = $urandom_range(0, int'(w) - 1);
          py = $urandom_range(0, int'(h) - 1);
        end
        queue_pixel(px, py);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_counts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_counts.size());
      mismatches++;
    end

    $display("Checked %0d of %0d pixels over %0d window settings, highest count %0d.",
             results_seen, pixels_sent, windows_used + 1, top_count);
    $display("Zero divisors, saturated steps, a zero limit and the full 16 bit limit included.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mpe_pkg.sv
hw/rtl/mpe_div.sv
hw/rtl/mpe_front.sv
hw/rtl/mpe_queue.sv
hw/rtl/mpe_iter.sv
hw/rtl/mandelbrot_pixel_engine_unit.sv
dv/mandelbrot_pixel_engine_unit_tb.sv
